// File: design/pfr_pkg.sv
// Package for the page frame replacement unit.
// Holds the default sizes, register indexes, controller states and the cell command type.
// No dependencies.
package pfr_pkg;

    localparam int DEF_MAX_FRAMES = 8;
    localparam int DEF_PAGE_BITS  = 16;

    localparam int REQ_PAGE_W  = 16;
    localparam int SLOT_W      = 3;
    localparam int FAULT_W     = 32;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 4;
    localparam int LIMIT_W     = 4;

    localparam logic [CFG_IDX_W-1:0] REG_POLICY_MODE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAMES_IN_USE = 1'b1;

    localparam logic POLICY_FIFO = 1'b0;
    localparam logic POLICY_LRU  = 1'b1;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic en;
        logic age_all;
    } cell_op_t;

endpackage

// File: design/pfr_cell.sv
// One page frame of the replacement chain: page, valid bit and age rank.
// Compares the request, adds its hit and victim data to the chain, and applies updates.
// Depends on pfr_pkg.
module pfr_cell #(
    parameter int PAGE_BITS = 16,
    parameter int RANK_W    = 3,
    parameter int IDX_W     = 3,
    parameter int CELL_IDX  = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [PAGE_BITS-1:0] req_page,
    input  logic [RANK_W-1:0]    oldest_rank,
    input  pfr_pkg::cell_op_t    op,
    input  logic [IDX_W-1:0]     target_idx,
    input  logic [RANK_W-1:0]    bound,
    input  logic                 hit_in,
    input  logic [IDX_W-1:0]     hit_idx_in,
    input  logic [RANK_W-1:0]    hit_rank_in,
    input  logic [IDX_W-1:0]     vic_idx_in,
    input  logic [PAGE_BITS-1:0] vic_page_in,
    output logic                 hit_out,
    output logic [IDX_W-1:0]     hit_idx_out,
    output logic [RANK_W-1:0]    hit_rank_out,
    output logic [IDX_W-1:0]     vic_idx_out,
    output logic [PAGE_BITS-1:0] vic_page_out
);
    import pfr_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [PAGE_BITS-1:0] page_reg;
    logic [PAGE_BITS-1:0] page_next;
    logic                 valid_reg;
    logic                 valid_next;
    logic [RANK_W-1:0]    rank_reg;
    logic [RANK_W-1:0]    rank_next;
    logic                 match;
    logic                 victim;
    logic                 target;
    logic                 age;

    assign match  = valid_reg && (page_reg == req_page);
    assign victim = valid_reg && (rank_reg == oldest_rank);
    assign target = op.en && (target_idx == MY_IDX);
    assign age    = op.en && valid_reg && (op.age_all || (rank_reg < bound));

    assign hit_out      = hit_in | match;
    assign hit_idx_out  = hit_idx_in | (match ? MY_IDX : '0);
    assign hit_rank_out = hit_rank_in | (match ? rank_reg : '0);
    assign vic_idx_out  = vic_idx_in | (victim ? MY_IDX : '0);
    assign vic_page_out = vic_page_in | (victim ? page_reg : '0);

    always_comb
    begin
        page_next  = page_reg;
        valid_next = valid_reg;
        rank_next  = rank_reg;
        if (target)
        begin
            page_next  = req_page;
            valid_next = 1'b1;
            rank_next  = '0;
        end
        else if (age)
        begin
            rank_next = rank_reg + RANK_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg <= page_next;
    end

endmodule

// File: design/page_frame_replacement_fifo_lru_unit.sv
// Top level of the FIFO / LRU page frame replacement unit.
// Holds the controller, configuration registers and the chain of pfr_cell frames.
// Depends on pfr_pkg and pfr_cell.
//
// Channel    Direction  Handshake        Payload
// request    in         start, busy      page_number
// result     out        done             hit, slot, evicted_valid, evicted_page, fault_count
// config     in         wr_en            wr_index, wr_data
//
// A request passes through the accept edge, a lookup cycle in which the frame chain
// resolves hit and victim, and an update cycle in which the frames apply the new ranks.
// The result strobe done is high during the update cycle and busy is low again after it.
// Reset clears all frames, the fault count and the configuration to its defaults.
// The receiver cannot stall; results are never held back.
module page_frame_replacement_fifo_lru_unit #(
    parameter int MAX_FRAMES = pfr_pkg::DEF_MAX_FRAMES,
    parameter int PAGE_BITS  = pfr_pkg::DEF_PAGE_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [pfr_pkg::REQ_PAGE_W-1:0]   page_number,
    output logic                             done,
    output logic                             hit,
    output logic [pfr_pkg::SLOT_W-1:0]       slot,
    output logic                             evicted_valid,
    output logic [pfr_pkg::REQ_PAGE_W-1:0]   evicted_page,
    output logic [pfr_pkg::FAULT_W-1:0]      fault_count,
    input  logic                             wr_en,
    input  logic [pfr_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [pfr_pkg::CFG_DATA_W-1:0]   wr_data
);
    import pfr_pkg::*;

    localparam int IDX_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int RANK_W = IDX_W;
    localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
    localparam int CMP_W  = ((CNT_W > LIMIT_W) ? CNT_W : LIMIT_W) + 1;
    localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_FRAMES);

    state_t state_reg;
    state_t state_next;
    logic   accept;
    logic   in_lookup;
    logic   in_update;

    logic                 policy_reg;
    logic [LIMIT_W-1:0]   limit_reg;
    logic [PAGE_BITS-1:0] req_reg;
    logic [CNT_W-1:0]     filled_reg;
    logic [FAULT_W-1:0]   faults_reg;

    logic                 op_en_reg;
    logic                 op_age_all_reg;
    logic [IDX_W-1:0]     target_reg;
    logic [RANK_W-1:0]    bound_reg;
    cell_op_t             op;

    logic                 done_reg;
    logic                 hit_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic                 ev_valid_reg;
    logic [REQ_PAGE_W-1:0] ev_page_reg;

    logic [PAGE_BITS+REQ_PAGE_W-1:0] req_ext;
    logic [CNT_W-1:0]     filled_m1;
    logic [RANK_W-1:0]    oldest_rank;
    logic [CMP_W-1:0]     limit_cmp;
    logic [CMP_W-1:0]     limit_eff;
    logic                 fill;
    logic                 found;
    logic [IDX_W-1:0]     slot_sel;
    logic [IDX_W+SLOT_W-1:0] slot_ext;
    logic [PAGE_BITS+REQ_PAGE_W-1:0] ev_ext;

    logic                 hit_ch      [0:MAX_FRAMES];
    logic [IDX_W-1:0]     hit_idx_ch  [0:MAX_FRAMES];
    logic [RANK_W-1:0]    hit_rank_ch [0:MAX_FRAMES];
    logic [IDX_W-1:0]     vic_idx_ch  [0:MAX_FRAMES];
    logic [PAGE_BITS-1:0] vic_page_ch [0:MAX_FRAMES];

    assign accept = start && (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy      = 1'b1;
        in_lookup = 1'b0;
        in_update = 1'b0;
        unique case (state_reg)
            ST_IDLE:   busy      = 1'b0;
            ST_LOOKUP: in_lookup = 1'b1;
            ST_UPDATE: in_update = 1'b1;
            default:   busy      = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POLICY_FIFO;
            limit_reg  <= LIMIT_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_POLICY_MODE:   policy_reg <= wr_data[0];
                REG_FRAMES_IN_USE: limit_reg  <= wr_data[LIMIT_W-1:0];
                default:           policy_reg <= policy_reg;
            endcase
        end
    end

    assign req_ext = {{PAGE_BITS{1'b0}}, page_number};

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req_ext[PAGE_BITS-1:0];
        end
    end

    assign filled_m1   = filled_reg - CNT_W'(1);
    assign oldest_rank = filled_m1[RANK_W-1:0];
    assign limit_cmp   = CMP_W'(limit_reg);

    always_comb
    begin
        priority if (limit_cmp == '0)
        begin
            limit_eff = CMP_W'(1);
        end
        else if (limit_cmp > MAX_CMP)
        begin
            limit_eff = MAX_CMP;
        end
        else
        begin
            limit_eff = limit_cmp;
        end
    end

    assign fill  = CMP_W'(filled_reg) < limit_eff;
    assign found = hit_ch[MAX_FRAMES];

    always_comb
    begin
        priority if (found)
        begin
            slot_sel = hit_idx_ch[MAX_FRAMES];
        end
        else if (fill)
        begin
            slot_sel = filled_reg[IDX_W-1:0];
        end
        else
        begin
            slot_sel = vic_idx_ch[MAX_FRAMES];
        end
    end

    assign slot_ext = {{SLOT_W{1'b0}}, slot_sel};
    assign ev_ext   = {{REQ_PAGE_W{1'b0}}, vic_page_ch[MAX_FRAMES]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg <= '0;
            faults_reg <= '0;
            done_reg   <= 1'b0;
            op_en_reg  <= 1'b0;
        end
        else
        begin
            done_reg  <= in_lookup;
            op_en_reg <= in_lookup && (!found || (policy_reg == POLICY_LRU));
            if (in_lookup && !found)
            begin
                if (faults_reg != '1)
                begin
                    faults_reg <= faults_reg + FAULT_W'(1);
                end
                if (fill)
                begin
                    filled_reg <= filled_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_lookup)
        begin
            op_age_all_reg <= !found && fill;
            target_reg     <= slot_sel;
            bound_reg      <= found ? hit_rank_ch[MAX_FRAMES] : oldest_rank;
            hit_reg        <= found;
            slot_reg       <= slot_ext[SLOT_W-1:0];
            ev_valid_reg   <= !found && !fill;
            ev_page_reg    <= (!found && !fill) ? ev_ext[REQ_PAGE_W-1:0] : '0;
        end
    end

    assign op.en      = op_en_reg && in_update;
    assign op.age_all = op_age_all_reg;

    assign hit_ch[0]      = 1'b0;
    assign hit_idx_ch[0]  = '0;
    assign hit_rank_ch[0] = '0;
    assign vic_idx_ch[0]  = '0;
    assign vic_page_ch[0] = '0;

    for (genvar g = 0; g < MAX_FRAMES; g++)
    begin : g_cell
        pfr_cell #(
            .PAGE_BITS (PAGE_BITS),
            .RANK_W    (RANK_W),
            .IDX_W     (IDX_W),
            .CELL_IDX  (g)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .req_page     (req_reg),
            .oldest_rank  (oldest_rank),
            .op           (op),
            .target_idx   (target_reg),
            .bound        (bound_reg),
            .hit_in       (hit_ch[g]),
            .hit_idx_in   (hit_idx_ch[g]),
            .hit_rank_in  (hit_rank_ch[g]),
            .vic_idx_in   (vic_idx_ch[g]),
            .vic_page_in  (vic_page_ch[g]),
            .hit_out      (hit_ch[g+1]),
            .hit_idx_out  (hit_idx_ch[g+1]),
            .hit_rank_out (hit_rank_ch[g+1]),
            .vic_idx_out  (vic_idx_ch[g+1]),
            .vic_page_out (vic_page_ch[g+1])
        );
    end

    assign done          = done_reg;
    assign hit           = hit_reg;
    assign slot          = slot_reg;
    assign evicted_valid = ev_valid_reg;
    assign evicted_page  = ev_page_reg;
    assign fault_count   = faults_reg;

endmodule

// File: design/pfr_checker.sv
// Port-level checker for the page frame replacement unit, with its bind statement.
// Watches request and result timing and the consistency of result fields.
// Depends on pfr_pkg and page_frame_replacement_fifo_lru_unit.
module pfr_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            start,
    input logic                            busy,
    input logic                            done,
    input logic                            hit,
    input logic                            evicted_valid,
    input logic [pfr_pkg::REQ_PAGE_W-1:0]  evicted_page,
    input logic [pfr_pkg::FAULT_W-1:0]     fault_count
);
    import pfr_pkg::*;

    a_result_timing: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("Result strobe missing two cycles after an accepted request.");

    a_done_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("Result strobe outside the request window.");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit) |-> !evicted_valid)
        else $error("Eviction reported on a hit.");

    a_evict_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !evicted_valid) |-> (evicted_page == '0))
        else $error("Evicted page is not zero without an eviction.");

    a_fault_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !hit) |-> (fault_count != '0))
        else $error("Fault count is zero after a page fault.");

endmodule

bind page_frame_replacement_fifo_lru_unit pfr_checker u_pfr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .hit           (hit),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .fault_count   (fault_count)
);
